// File: src/rxd_pkg.sv
`default_nettype none

package rxd_pkg;

  // Ring store geometry
  localparam int DEPTH = 128;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Header layout
  localparam int LEN_W  = 5;
  localparam int TYPE_W = 3;

  // Operation codes of an input transaction
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Classified command handed from the front queue to the back end
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } cmd_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// File: src/rxd_if.sv
`default_nettype none

interface rxd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface rxd_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic       is_header;
  logic [2:0] msg_type;
  logic [4:0] msg_length;
  logic [7:0] data_byte;
  logic       last;

  modport source (
    output valid, output ok, output is_header, output msg_type,
    output msg_length, output data_byte, output last, input ready
  );
  modport sink (
    input valid, input ok, input is_header, input msg_type,
    input msg_length, input data_byte, input last, output ready
  );
endinterface

`default_nettype wire

// File: src/rxd_front.sv
`default_nettype none

module rxd_front (
  input  logic          clk,
  input  logic          rst,
  rxd_in_if.sink        rx_in,
  output logic          q_valid,
  output rxd_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import rxd_pkg::*;

  cmd_t       slot [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] used;
  logic [1:0] used_next;
  logic       take;

  assign rx_in.ready = (used != 2'd2);
  assign take        = rx_in.valid & rx_in.ready;
  assign q_valid     = (used != 2'd0);
  assign q_cmd       = slot[rd_sel];

  always_comb begin
    used_next = used;
    if (take && !q_pop) begin
      used_next = used + 2'd1;
    end else if (!take && q_pop) begin
      used_next = used - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (take) wr_sel <= ~wr_sel;
      if (q_pop) rd_sel <= ~rd_sel;
      used <= used_next;
    end
  end

  // classify on entry: op says push or whole-message read
  always_ff @(posedge clk) begin
    if (take) begin
      slot[wr_sel].op   <= (rx_in.operation == OP_READ) ? OP_READ : OP_PUSH;
      slot[wr_sel].data <= rx_in.rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: src/rxd_back.sv
`default_nettype none

module rxd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rxd_pkg::cmd_t q_cmd,
  output logic          q_pop,
  rxd_out_if.source     msg_out
);
  import rxd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state, state_next;
  ptr_t             rp, rp_next, wp, wp_next;
  cnt_t             fill, fill_next;
  logic [LEN_W-1:0] left, left_next;

  logic [7:0]       store [DEPTH];
  logic [7:0]       rd_data;
  logic             rd_en;
  ptr_t             rd_addr;
  logic             we;

  logic              o_valid;
  logic              o_ok, o_hdr, o_last;
  logic [TYPE_W-1:0] o_type;
  logic [LEN_W-1:0]  o_len;
  logic [7:0]        o_data;
  logic              ok_n, hdr_n, last_n;
  logic [TYPE_W-1:0] type_n;
  logic [LEN_W-1:0]  len_n;
  logic [7:0]        data_n;
  logic              load;

  logic              can_load;
  logic [LEN_W-1:0]  hdr_len;
  logic              short_msg;
  ptr_t              rp1, rp2;
  cnt_t              unissued;
  logic              room;
  logic              is_push;

  assign can_load  = !o_valid || msg_out.ready;
  assign hdr_len   = rd_data[LEN_W-1:0];
  // empty store fails without looking at the fetched header byte
  assign short_msg = (fill == '0) || (fill <= CNT_W'(hdr_len));
  assign rp1       = ptr_inc(rp);
  assign rp2       = ptr_inc(rp1);
  // payload bytes committed but not yet fetched still occupy the store
  assign unissued  = (state == ST_EMIT) ? CNT_W'(left - 1'b1) : '0;
  assign room      = (fill + unissued) < CNT_W'(DEPTH);
  assign is_push   = (q_cmd.op == OP_PUSH);

  always_comb begin
    state_next = state;
    rp_next    = rp;
    wp_next    = wp;
    fill_next  = fill;
    left_next  = left;
    q_pop      = 1'b0;
    we         = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = rp;
    load       = 1'b0;
    ok_n       = 1'b0;
    hdr_n      = 1'b0;
    type_n     = '0;
    len_n      = '0;
    data_n     = '0;
    last_n     = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (q_valid && !is_push) begin
          rd_en      = 1'b1;
          state_next = ST_HDR;
        end
      end
      ST_HDR: begin
        if (can_load) begin
          load  = 1'b1;
          q_pop = 1'b1;
          if (short_msg) begin
            state_next = ST_IDLE;
          end else begin
            ok_n      = 1'b1;
            hdr_n     = 1'b1;
            type_n    = rd_data[7:8-TYPE_W];
            len_n     = hdr_len;
            last_n    = (hdr_len == '0);
            fill_next = fill - CNT_W'(hdr_len) - 1'b1;
            if (hdr_len == '0) begin
              rp_next    = rp1;
              state_next = ST_IDLE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = rp1;
              rp_next    = rp2;
              left_next  = hdr_len;
              state_next = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          load   = 1'b1;
          ok_n   = 1'b1;
          data_n = rd_data;
          last_n = (left == LEN_W'(1));
          if (left == LEN_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            rd_en     = 1'b1;
            rp_next   = rp1;
            left_next = left - 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // pushes go on while idle or while a committed message drains
    if (q_valid && is_push && (state == ST_IDLE || state == ST_EMIT)) begin
      if (fill == CNT_W'(DEPTH)) begin
        q_pop = 1'b1;
      end else if (room) begin
        q_pop     = 1'b1;
        we        = 1'b1;
        wp_next   = ptr_inc(wp);
        fill_next = fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rp      <= '0;
      wp      <= '0;
      fill    <= '0;
      left    <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      rp    <= rp_next;
      wp    <= wp_next;
      fill  <= fill_next;
      left  <= left_next;
      if (load) begin
        o_valid <= 1'b1;
      end else if (msg_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) store[wp] <= q_cmd.data;
    if (rd_en) rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_ok   <= ok_n;
      o_hdr  <= hdr_n;
      o_type <= type_n;
      o_len  <= len_n;
      o_data <= data_n;
      o_last <= last_n;
    end
  end

  assign msg_out.valid      = o_valid;
  assign msg_out.ok         = o_ok;
  assign msg_out.is_header  = o_hdr;
  assign msg_out.msg_type   = o_type;
  assign msg_out.msg_length = o_len;
  assign msg_out.data_byte  = o_data;
  assign msg_out.last       = o_last;

endmodule

`default_nettype wire

// File: src/rx_message_ring_deframer.sv
`default_nettype none

// Channel   Dir  Handshake      Payload
// rx_in     in   valid/ready    operation, rx_byte
// msg_out   out  valid/ready    ok, is_header, msg_type, msg_length, data_byte, last
//
// Every transaction enters a two-entry queue; the back end retires at most one per
// cycle, and a read holds the queue head through its header fetch and its result.
// A push is stored (or dropped when full) as it is popped off the queue head. A read
// fetches its header byte from the ring store, then registers its header or failure
// result, then one payload result per cycle while the receiver accepts, paced by the
// single read port of the ring store. Pushes keep flowing while a message drains;
// they stall only behind a read awaiting its header, or while unread payload bytes
// still fill the store. Reset clears pointers, counts and queue, not store contents.
module rx_message_ring_deframer (
  input  logic      clk,
  input  logic      rst,
  rxd_in_if.sink    rx_in,
  rxd_out_if.source msg_out
);
  import rxd_pkg::*;

  // classified commands between front queue and back end
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  rxd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx_in   (rx_in),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // ring store, fill accounting, message sequencer and output register
  rxd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .msg_out (msg_out)
  );

endmodule

`default_nettype wire

// File: tb/rx_message_ring_deframer_test.sv
import rxd_pkg::*;

// One result of a read request, laid out as on msg_out
typedef struct packed {
  logic       ok;
  logic       is_header;
  logic [2:0] msg_type;
  logic [4:0] msg_length;
  logic [7:0] data_byte;
  logic       last;
} msg_res_t;

// Mirror of the ring store plus the queue of results still owed by the block
class ring_mirror;
  logic [7:0] bytes_held [DEPTH];
  int unsigned oldest;
  int unsigned next_free;
  int unsigned held;
  msg_res_t due[$];
  int unsigned mismatches;

  function new();
    oldest = 0;
    next_free = 0;
    held = 0;
    mismatches = 0;
  endfunction

  // Accepted input transaction: update the mirror, queue what it must produce
  function void take_rx(logic op, logic [7:0] b);
    logic [7:0] hdr;
    int unsigned len;
    msg_res_t res;
    res = '0;
    if (op == OP_PUSH) begin
      // full store drops the byte
      if (held < DEPTH) begin
        bytes_held[next_free] = b;
        next_free = (next_free + 1) % DEPTH;
        held++;
      end
    end else if (held == 0) begin
      res.last = 1'b1;
      due.push_back(res);
    end else begin
      hdr = bytes_held[oldest];
      len = hdr[4:0];
      if (held < len + 1) begin
        // incomplete message: nothing consumed
        res.last = 1'b1;
        due.push_back(res);
      end else begin
        oldest = (oldest + 1) % DEPTH;
        held--;
        res.ok = 1'b1;
        res.is_header = 1'b1;
        res.msg_type = hdr[7:5];
        res.msg_length = hdr[4:0];
        res.last = (len == 0);
        due.push_back(res);
        for (int unsigned i = 0; i < len; i++) begin
          res = '0;
          res.ok = 1'b1;
          res.data_byte = bytes_held[oldest];
          res.last = (i + 1 == len);
          oldest = (oldest + 1) % DEPTH;
          held--;
          due.push_back(res);
        end
      end
    end
  endfunction

  function void report(string what, msg_res_t want, msg_res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected ok=%0d hdr=%0d type=%0d len=%0d data=%02h last=%0d", what,
               want.ok, want.is_header, want.msg_type, want.msg_length, want.data_byte,
               want.last);
      $display("    got ok=%0d hdr=%0d type=%0d len=%0d data=%02h last=%0d",
               got.ok, got.is_header, got.msg_type, got.msg_length, got.data_byte,
               got.last);
    end
  endfunction

  // Accepted output transaction: compare with the oldest owed result
  function void match_result(msg_res_t got);
    msg_res_t want;
    if (due.size() == 0) begin
      report("unexpected result", '0, got);
    end else begin
      want = due.pop_front();
      if (got.ok !== want.ok || got.is_header !== want.is_header ||
          got.msg_type !== want.msg_type || got.msg_length !== want.msg_length ||
          got.data_byte !== want.data_byte || got.last !== want.last) begin
        report("result mismatch", want, got);
      end
    end
  endfunction
endclass

module rx_message_ring_deframer_test;

  // Generous cycle budget: worst case is every read giving 32 results, each
  // one held up by random receiver stalls, plus the long hold-off.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  // Quiet cycles after the last result so that pushes still in flight land
  localparam int unsigned SETTLE = 20;
  localparam int unsigned IDLE_PCT = 28;

  logic clk;
  logic rst;

  rxd_in_if  rx_in();
  rxd_out_if msg_out();

  rx_message_ring_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .rx_in   (rx_in),
    .msg_out (msg_out)
  );

  ring_mirror book = new();

  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  // steady: neither side idles (the long no-idle stretch)
  bit steady = 1'b0;
  // Hold-off requests from the stimulus; the receiver counts them off itself
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  msg_res_t seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver side. Ready is decided at the falling edge; a pending hold-off
  // request turns into a stretch of ready low that HOLD_CYCLES sets, counted here.
  initial begin
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        msg_out.ready <= 1'b0;
      end else if (steady) begin
        msg_out.ready <= 1'b1;
      end else begin
        msg_out.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Every output transaction is checked at the rising edge it completes on
  always @(posedge clk) begin
    if (!rst && msg_out.valid && msg_out.ready) begin
      seen.ok = msg_out.ok;
      seen.is_header = msg_out.is_header;
      seen.msg_type = msg_out.msg_type;
      seen.msg_length = msg_out.msg_length;
      seen.data_byte = msg_out.data_byte;
      seen.last = msg_out.last;
      book.match_result(seen);
    end
  end

  // One input transaction. Entered and left at a falling edge, so valid
  // gets a single assignment per time step whether it stays up or drops.
  task automatic send_item(input logic op, input logic [7:0] b);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        rx_in.valid <= 1'b0;
        @(negedge clk);
      end
    end
    rx_in.valid <= 1'b1;
    rx_in.operation <= op;
    rx_in.rx_byte <= b;
    do @(posedge clk); while (!rx_in.ready);
    book.take_rx(op, b);
    items_sent++;
    @(negedge clk);
  endtask

  // Well-formed message: header, len payload bytes, optionally the read
  task automatic push_message(input int unsigned len, input bit then_read);
    logic [7:0] hdr;
    hdr = {3'($urandom_range(7)), 5'(len)};
    send_item(OP_PUSH, hdr);
    repeat (len) send_item(OP_PUSH, 8'($urandom));
    if (then_read) send_item(OP_READ, 8'($urandom));
  endtask

  // Mostly short payloads, now and then any length, sometimes the longest
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 31;
    if (r < 3) return $urandom_range(31);
    return $urandom_range(6);
  endfunction

  // One random episode: mostly whole messages, some bare reads,
  // messages split by a premature read, and stray bytes that break framing
  task automatic random_episode();
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [7:0] hdr;
    pick = $urandom_range(99);
    len = pick_length();
    if (pick < 65) begin
      push_message(len, $urandom_range(4) != 0);
    end else if (pick < 80) begin
      send_item(OP_READ, 8'($urandom));
    end else if (pick < 90 && len > 0) begin
      cut = $urandom_range(len - 1);
      hdr = {3'($urandom_range(7)), 5'(len)};
      send_item(OP_PUSH, hdr);
      repeat (cut) send_item(OP_PUSH, 8'($urandom));
      send_item(OP_READ, 8'($urandom));
      repeat (len - cut) send_item(OP_PUSH, 8'($urandom));
      send_item(OP_READ, 8'($urandom));
    end else begin
      send_item(OP_PUSH, 8'($urandom));
    end
  endtask

  // Sender stops offering until every owed result has come, then lets the
  // block settle
  task automatic wait_drained();
    rx_in.valid <= 1'b0;
    while (book.due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int unsigned bytes_pushed;
    int unsigned msgs;
    int unsigned len;

    rst = 1'b1;
    rx_in.valid = 1'b0;
    rx_in.operation = OP_PUSH;
    rx_in.rx_byte = 8'h00;
    msg_out.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: read on an empty store
    send_item(OP_READ, 8'h00);
    // zero-length message, top type: header result only, marked last
    send_item(OP_PUSH, 8'hE0);
    send_item(OP_READ, 8'hFF);
    // incomplete message is refused and left in place, then completes
    send_item(OP_PUSH, 8'h02);
    send_item(OP_PUSH, 8'h00);
    send_item(OP_READ, 8'h00);
    send_item(OP_PUSH, 8'hFF);
    send_item(OP_READ, 8'h00);
    // single-byte payload, then the store is empty again
    send_item(OP_PUSH, 8'h41);
    send_item(OP_PUSH, 8'hA5);
    send_item(OP_READ, 8'h5A);
    send_item(OP_READ, 8'h00);

    // Random traffic with idling on both sides
    while (items_sent < 150) random_episode();

    // Long stretch with no idling at all
    steady = 1'b1;
    while (items_sent < 230) random_episode();
    steady = 1'b0;

    // Pressure: receiver holds off while the sender keeps going. Enough
    // whole messages to overrun the store (tail bytes dropped), then reads
    // that queue up behind the stalled output and stall the input.
    holds_asked++;
    bytes_pushed = 0;
    msgs = 0;
    while (bytes_pushed < DEPTH + 8) begin
      len = $urandom_range(7);
      push_message(len, 1'b0);
      bytes_pushed += len + 1;
      msgs++;
    end
    repeat (msgs + 2) send_item(OP_READ, 8'($urandom));

    // Sender pauses until the block has caught up entirely
    wait_drained();

    while (items_sent < 410) random_episode();

    wait_drained();
    if (book.mismatches == 0 && book.due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
